// ===== rtl/core/euler_to_quaternion_unit_defines.svh =====
// assertion macros for the euler to quaternion core
`ifndef EULER_TO_QUATERNION_UNIT_DEFINES_SVH
`define EULER_TO_QUATERNION_UNIT_DEFINES_SVH

// next-cycle implication, ignored while in reset
`define ETQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked during reset
`define ETQ_ASSERT_ALWAYS(lbl, clk_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/etq_pkg.sv =====
// types, constants and arithmetic helpers for the euler to quaternion core
`default_nettype none
package etq_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int QUAT_FRAC_BITS  = 30;

  localparam int LANE_STAGES = 12;
  localparam int NSTAGE      = LANE_STAGES + 3;

  typedef logic signed [33:0] q_t;
  typedef logic signed [31:0] word_t;

  localparam logic [31:0] FULL_ANG = 32'(64'd360 << ANGLE_FRAC_BITS);
  localparam logic [31:0] HALF_ANG = 32'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic [23:0] RECIP    = 24'((64'd1 << 24) / 64'd360);
  localparam logic [29:0] HRAD_K   = 30'((64'h3243F6A8885A308D >> 24) / 64'd360);
  localparam int          Y_SH     = ANGLE_FRAC_BITS + 6;
  localparam logic [63:0] Y_RND    = 64'd1 << (ANGLE_FRAC_BITS + 5);

  localparam q_t SIN_C [6] = '{-34'sd26, 34'sd2956, -34'sd213040, 34'sd8947846,
                               -34'sd178956974, 34'sd1073741824};
  localparam q_t COS_C [6] = '{-34'sd280, 34'sd26586, -34'sd1491253, 34'sd44739212,
                               -34'sd536870912, 34'sd1073741824};

  localparam int Q_SH   = 30 - QUAT_FRAC_BITS;
  localparam int RND_SH = (Q_SH == 0) ? 0 : Q_SH - 1;

  // q30 product, magnitude rounded half up
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [33:0] ma;
    logic [33:0] mb;
    logic [67:0] p;
    logic [33:0] m;
    ma = a[33] ? $unsigned(-a) : $unsigned(a);
    mb = b[33] ? $unsigned(-b) : $unsigned(b);
    p  = 68'(ma) * 68'(mb) + (68'd1 << 29);
    m  = p[63:30];
    return (a[33] ^ b[33]) ? -$signed(m) : $signed(m);
  endfunction

  // saturate, round to output fraction and saturate again
  function automatic word_t finish(input logic signed [34:0] v);
    logic signed [34:0] s;
    logic [34:0]        m;
    logic               neg;
    if (v > 35'sd2147483647) begin
      s = 35'sd2147483647;
    end else if (v < -35'sd2147483648) begin
      s = -35'sd2147483648;
    end else begin
      s = v;
    end
    neg = s[34];
    m   = neg ? $unsigned(-s) : $unsigned(s);
    if (Q_SH > 0) begin
      m = (m + (35'd1 << RND_SH)) >> Q_SH;
    end
    s = neg ? -$signed(m) : $signed(m);
    if (s > 35'sd2147483647) begin
      s = 35'sd2147483647;
    end
    return word_t'(s);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/etq_sincos.sv =====
// pipelined angle reduction and sine/cosine evaluation for one angle
`default_nettype none
module etq_sincos (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire etq_pkg::word_t ang_deg,
  output etq_pkg::q_t        sin_o,
  output etq_pkg::q_t        cos_o
);
  import etq_pkg::*;

  logic [31:0] mag0;
  logic [47:0] qprod0;
  logic [63:0] yprod4;

  logic        neg1_r, neg2_r, neg3_r, neg4_r, neg5_r, neg6_r;
  logic        flip4_r, flip5_r, flip6_r;
  logic [31:0] mag1_r, rem2_r, rem3_r, m4_r;
  logic [15:0] qe1_r;
  q_t          y5_r, y6_r, y2_6_r;

  q_t          hs_r [5];
  q_t          hc_r [5];
  q_t          hy_r [5];
  q_t          hy2_r [5];
  logic        hn_r [5];
  logic        hf_r [5];

  q_t          sin_r, cos_r;

  assign mag0   = ang_deg[31] ? 32'(-ang_deg) : 32'(ang_deg);
  assign qprod0 = 48'(mag0 >> ANGLE_FRAC_BITS) * 48'(RECIP);
  assign yprod4 = 64'(m4_r) * 64'(HRAD_K) + Y_RND;

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitude and quotient estimate
      neg1_r <= ang_deg[31];
      mag1_r <= mag0;
      qe1_r  <= qprod0[39:24];
      // remainder, one short at most
      neg2_r <= neg1_r;
      rem2_r <= mag1_r - 32'(48'(qe1_r) * 48'(FULL_ANG));
      // correction
      neg3_r <= neg2_r;
      rem3_r <= (rem2_r >= FULL_ANG) ? rem2_r - FULL_ANG : rem2_r;
      // fold into the half turn
      neg4_r  <= neg3_r;
      flip4_r <= rem3_r > HALF_ANG;
      m4_r    <= (rem3_r > HALF_ANG) ? FULL_ANG - rem3_r : rem3_r;
      // half angle in radians
      neg5_r  <= neg4_r;
      flip5_r <= flip4_r;
      y5_r    <= $signed(yprod4[Y_SH +: 34]);
      // square
      neg6_r  <= neg5_r;
      flip6_r <= flip5_r;
      y6_r    <= y5_r;
      y2_6_r  <= qmul(y5_r, y5_r);
      // horner steps
      hs_r[0]  <= qmul(SIN_C[0], y2_6_r) + SIN_C[1];
      hc_r[0]  <= qmul(COS_C[0], y2_6_r) + COS_C[1];
      hy_r[0]  <= y6_r;
      hy2_r[0] <= y2_6_r;
      hn_r[0]  <= neg6_r;
      hf_r[0]  <= flip6_r;
      for (int k = 1; k < 5; k++) begin
        hs_r[k]  <= qmul(hs_r[k-1], hy2_r[k-1]) + SIN_C[k+1];
        hc_r[k]  <= qmul(hc_r[k-1], hy2_r[k-1]) + COS_C[k+1];
        hy_r[k]  <= hy_r[k-1];
        hy2_r[k] <= hy2_r[k-1];
        hn_r[k]  <= hn_r[k-1];
        hf_r[k]  <= hf_r[k-1];
      end
      // odd term and signs
      sin_r <= hn_r[4] ? -qmul(hs_r[4], hy_r[4]) : qmul(hs_r[4], hy_r[4]);
      cos_r <= hf_r[4] ? -hc_r[4] : hc_r[4];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule
`default_nettype wire

// ===== rtl/core/euler_to_quaternion_unit.sv =====
// euler to quaternion top level: three angle lanes, products and output stage
// 15 register stages between the input transfer and the result
// throughput: one angle triple per cycle while no result is stalled, set by the fully pipelined lanes
// a stalled result holds the whole pipeline in place
// reset clears the valid bits only; no clearing pass
`default_nettype none
`include "euler_to_quaternion_unit_defines.svh"
module euler_to_quaternion_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire etq_pkg::word_t in_pitch_deg,
  input  wire etq_pkg::word_t in_yaw_deg,
  input  wire etq_pkg::word_t in_roll_deg,
  output logic                out_valid,
  input  wire logic           out_ready,
  output etq_pkg::word_t      out_quat_x,
  output etq_pkg::word_t      out_quat_y,
  output etq_pkg::word_t      out_quat_z,
  output etq_pkg::word_t      out_quat_w
);
  import etq_pkg::*;

  logic              en;
  logic [NSTAGE-1:0] v_r, v_nxt;

  q_t sp, cp, sy, cy, sr, cr;
  q_t a1_r, a2_r, a3_r, a4_r;
  q_t sy_d_r, cy_d_r;
  q_t x1_r, x2_r, y1_r, y2_r, z1_r, z2_r, w1_r, w2_r;
  word_t qx_r, qy_r, qz_r, qw_r;

  assign en       = !v_r[NSTAGE-1] || out_ready;
  assign in_ready = en;
  assign v_nxt    = en ? {v_r[NSTAGE-2:0], in_valid} : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  etq_sincos u_pitch (.clk(clk), .en(en), .ang_deg(in_pitch_deg), .sin_o(sp), .cos_o(cp));
  etq_sincos u_yaw   (.clk(clk), .en(en), .ang_deg(in_yaw_deg),   .sin_o(sy), .cos_o(cy));
  etq_sincos u_roll  (.clk(clk), .en(en), .ang_deg(in_roll_deg),  .sin_o(sr), .cos_o(cr));

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= qmul(cr, sp);
      a2_r <= qmul(sr, cp);
      a3_r <= qmul(cr, cp);
      a4_r <= qmul(sr, sp);
      // yaw terms kept in step with the partial products
      sy_d_r <= sy;
      cy_d_r <= cy;
      x1_r <= qmul(a1_r, sy_d_r);
      x2_r <= qmul(a2_r, cy_d_r);
      y1_r <= qmul(a1_r, cy_d_r);
      y2_r <= qmul(a2_r, sy_d_r);
      z1_r <= qmul(a3_r, sy_d_r);
      z2_r <= qmul(a4_r, cy_d_r);
      w1_r <= qmul(a3_r, cy_d_r);
      w2_r <= qmul(a4_r, sy_d_r);
      qx_r <= finish(35'(x1_r) - 35'(x2_r));
      qy_r <= finish(-35'(y1_r) - 35'(y2_r));
      qz_r <= finish(35'(z1_r) - 35'(z2_r));
      qw_r <= finish(35'(w1_r) + 35'(w2_r));
    end
  end

  assign out_valid  = v_r[NSTAGE-1];
  assign out_quat_x = qx_r;
  assign out_quat_y = qy_r;
  assign out_quat_z = qz_r;
  assign out_quat_w = qw_r;

  `ETQ_ASSERT_NEXT(a_enter, clk, rst_n, in_valid && in_ready, v_r[0], "transfer not tracked")
  `ETQ_ASSERT_NEXT(a_hold, clk, rst_n, !en, $stable(v_r), "valid bits moved during stall")
  `ETQ_ASSERT_ALWAYS(a_rst, clk, !rst_n, !out_valid, "result valid after reset")

endmodule
`default_nettype wire

// ===== tb/sv/euler_to_quaternion_unit_test.sv =====
// testbench for the euler to quaternion unit: predicts each quaternion and checks every result
`default_nettype none
module euler_to_quaternion_unit_test;

  typedef struct packed {
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [31:0] roll;
  } angles_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } quat_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam longint unsigned HALF_RAD_K = (64'h3243F6A8885A308D >> 24) / 64'd360;
  localparam longint SIN_K [6] = '{-26, 2956, -213040, 8947846, -178956974, 1073741824};
  localparam longint COS_K [6] = '{-280, 26586, -1491253, 44739212, -536870912, 1073741824};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  etq_pkg::word_t in_pitch_deg;
  etq_pkg::word_t in_yaw_deg;
  etq_pkg::word_t in_roll_deg;
  logic out_valid;
  logic out_ready;
  etq_pkg::word_t out_quat_x;
  etq_pkg::word_t out_quat_y;
  etq_pkg::word_t out_quat_z;
  etq_pkg::word_t out_quat_w;

  angles_t pending_angles[$];
  quat_t expected_quats[$];
  int error_count;
  int idle_cycles;
  int cycle_count;
  bit calm_phase;

  euler_to_quaternion_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pitch_deg(in_pitch_deg), .in_yaw_deg(in_yaw_deg), .in_roll_deg(in_roll_deg),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w)
  );

  function automatic longint q30_mul(longint a, longint b);
    bit neg;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned m;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    m = (ma * mb + (64'd1 << 29)) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void angle_sin_cos(logic signed [31:0] ang, output longint s,
                                        output longint c);
    longint full_turn;
    longint half_turn;
    longint rem;
    longint unsigned mag;
    longint half_angle;
    longint y2;
    longint ps;
    longint pc;
    bit folded;
    full_turn = longint'(360) << etq_pkg::ANGLE_FRAC_BITS;
    half_turn = longint'(180) << etq_pkg::ANGLE_FRAC_BITS;
    rem = longint'(ang) % full_turn;
    mag = rem < 0 ? -rem : rem;
    folded = 0;
    if (mag > half_turn) begin
      mag = full_turn - mag;
      folded = 1;
    end
    half_angle = (mag * HALF_RAD_K + (64'd1 << (etq_pkg::ANGLE_FRAC_BITS + 5)))
                 >> (etq_pkg::ANGLE_FRAC_BITS + 6);
    y2 = q30_mul(half_angle, half_angle);
    ps = SIN_K[0];
    pc = COS_K[0];
    for (int i = 1; i < 6; i++) begin
      ps = q30_mul(ps, y2) + SIN_K[i];
      pc = q30_mul(pc, y2) + COS_K[i];
    end
    ps = q30_mul(ps, half_angle);
    s = rem < 0 ? -ps : ps;
    c = folded ? -pc : pc;
  endfunction

  function automatic logic signed [31:0] to_output(longint v30);
    longint v;
    longint unsigned m;
    bit neg;
    int sh;
    v = clamp32(v30);
    sh = 30 - etq_pkg::QUAT_FRAC_BITS;
    neg = v < 0;
    m = neg ? -v : v;
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    v = clamp32(neg ? -longint'(m) : longint'(m));
    return v[31:0];
  endfunction

  function automatic quat_t euler_to_quat(angles_t a);
    longint sp, cp, sy, cy, sr, cr;
    quat_t q;
    angle_sin_cos(a.pitch, sp, cp);
    angle_sin_cos(a.yaw, sy, cy);
    angle_sin_cos(a.roll, sr, cr);
    q.x = to_output(q30_mul(q30_mul(cr, sp), sy) - q30_mul(q30_mul(sr, cp), cy));
    q.y = to_output(-q30_mul(q30_mul(cr, sp), cy) - q30_mul(q30_mul(sr, cp), sy));
    q.z = to_output(q30_mul(q30_mul(cr, cp), sy) - q30_mul(q30_mul(sr, sp), cy));
    q.w = to_output(q30_mul(q30_mul(cr, cp), cy) + q30_mul(q30_mul(sr, sp), sy));
    return q;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [31:0] random_angle();
    logic signed [31:0] deg;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return {$urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000};
      2: begin
        deg = $signed($urandom_range(0, 1440)) - 720;
        return (deg <<< 16) + $signed($urandom_range(0, 3)) - 1;
      end
      default: return $signed($urandom_range(0, 32'h02d00000 * 2)) - 32'sh02d00000;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    logic signed [31:0] edges [12];
    angles_t a;
    edges = '{32'sh0, 32'sh7fffffff, -32'sh80000000, 32'sh00b40000, -32'sh00b40000,
              32'sh00b40001, 32'sh00b3ffff, 32'sh01680000, -32'sh01680000,
              32'sh005a0000, -32'sh005a0000, 32'sh1};
    foreach (edges[i]) begin
      a.pitch = edges[i];
      a.yaw = edges[(i + 4) % 12];
      a.roll = edges[(i + 7) % 12];
      pending_angles.push_back(a);
    end
    pending_angles.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    pending_angles.push_back('{-32'sh80000000, -32'sh80000000, -32'sh80000000});
    pending_angles.push_back('{32'sh00b40000, 32'sh00b40000, 32'sh00b40000});
    pending_angles.push_back('{32'shffffffff, 32'sh0, 32'shffffffff});
    for (int i = 0; i < 750; i++) begin
      a.pitch = random_angle();
      a.yaw = random_angle();
      a.roll = random_angle();
      pending_angles.push_back(a);
    end
  end

  initial begin
    error_count = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
  end

  // calm stretch with no idling on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end
  assign calm_phase = (cycle_count >= 300 && cycle_count < 600);

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_pitch_deg <= '0;
      in_yaw_deg <= '0;
      in_roll_deg <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_angles.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 25)) begin
        in_valid <= 1;
        in_pitch_deg <= pending_angles[0].pitch;
        in_yaw_deg <= pending_angles[0].yaw;
        in_roll_deg <= pending_angles[0].roll;
        void'(pending_angles.pop_front());
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      out_ready <= calm_phase || $urandom_range(0, 99) >= 25;
    end
  end

  // prediction on input transfer, check on result transfer
  always @(posedge clk) begin
    quat_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_quats.push_back(euler_to_quat('{in_pitch_deg, in_yaw_deg, in_roll_deg}));
      if (out_valid && out_ready) begin
        if (expected_quats.size() == 0) begin
          $display("unexpected result transfer");
          error_count++;
        end else begin
          want = expected_quats.pop_front();
          if (out_quat_x !== want.x) report_mismatch("quat_x", out_quat_x, want.x);
          if (out_quat_y !== want.y) report_mismatch("quat_y", out_quat_y, want.y);
          if (out_quat_z !== want.z) report_mismatch("quat_z", out_quat_z, want.z);
          if (out_quat_w !== want.w) report_mismatch("quat_w", out_quat_w, want.w);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("euler_to_quaternion_unit_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    @(posedge rst_n);
    wait (pending_angles.size() == 0 && !in_valid);
    @(posedge clk);
    wait (expected_quats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_quats.size() == 0) begin
      $display("euler_to_quaternion_unit_test: done, clean");
    end else begin
      $display("euler_to_quaternion_unit_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
